[src/bud_pkg.sv]
// Shared types and constants for the byte unstuffing deframer.
// No dependencies; every other file imports this package.
package bud_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h41;
  localparam logic [7:0] ESC_BYTE   = 8'h42;
  localparam logic [7:0] ESC_DELIM  = 8'h43;
  localparam logic [7:0] ESC_ESC    = 8'h44;

  localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_DELIM,
    KIND_ESC,
    KIND_ESC_DELIM,
    KIND_ESC_ESC
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_FRAME,
    PH_ESCAPE
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_END,
    ST_BADESC,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_beat_t;

  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    case (b)
      DELIM_BYTE: k = KIND_DELIM;
      ESC_BYTE:   k = KIND_ESC;
      ESC_DELIM:  k = KIND_ESC_DELIM;
      ESC_ESC:    k = KIND_ESC_ESC;
      default:    k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

[src/bud_front.sv]
// Input stage: takes line bytes from the slave stream and tags each with its kind.
// Depends on bud_pkg.
module bud_front
  import bud_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // line_byte
  output item_beat_t push,
  input  logic       push_ready
);

  logic  valid;
  item_t item;

  assign s_tready   = !valid || push_ready;
  assign push.valid = valid;
  assign push.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (push_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.value <= s_tdata;
      item.kind  <= classify(s_tdata);
    end
  end

endmodule

[src/bud_queue.sv]
// Small FIFO of classified items between the input stage and the decoder.
// Depends on bud_pkg.
module bud_queue
  import bud_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  item_beat_t push,
  output logic       push_ready,
  output item_beat_t pop,
  input  logic       pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign push_ready = (count != CW'(DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.item   = mem[rd_ptr];
  assign do_wr      = push.valid && push_ready;
  assign do_rd      = pop.valid && pop_ready;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= push.item;
    end
  end

endmodule

[src/bud_back.sv]
// Decoder: runs the hunt/frame/escape state machine and holds the result register.
// Depends on bud_pkg.
module bud_back
  import bud_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] max_frame_bytes,
  input  item_beat_t  pop,
  output logic        pop_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // data_byte [7:0], frame_length [23:8]
  output logic [1:0]  m_tuser     // status
);

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] count;
  logic [15:0] count_next;

  logic        res_valid;
  status_t     res_status;
  logic [7:0]  res_data;
  logic [15:0] res_len;

  logic        out_valid;
  logic [7:0]  out_data;
  status_t     out_status;
  logic [15:0] out_len;

  logic        take;
  logic        full;

  // An item may leave the queue whenever the result register is free or drains now.
  assign pop_ready = !out_valid || m_tready;
  assign take      = pop.valid && pop_ready;
  assign full      = (count >= max_frame_bytes);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_FRAME: begin
        case (pop.item.kind)
          KIND_DELIM: phase_next = PH_HUNT;
          KIND_ESC:   phase_next = PH_ESCAPE;
          default:    phase_next = full ? PH_HUNT : PH_FRAME;
        endcase
      end
      PH_ESCAPE: begin
        if (pop.item.kind inside {KIND_ESC_DELIM, KIND_ESC_ESC}) begin
          phase_next = full ? PH_HUNT : PH_FRAME;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = (pop.item.kind == KIND_DELIM) ? PH_FRAME : PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_DATA;
    res_data   = '0;
    res_len    = '0;
    count_next = count;
    case (phase)
      PH_FRAME: begin
        case (pop.item.kind)
          KIND_DELIM: begin
            res_valid  = 1'b1;
            res_status = ST_END;
            res_len    = count;
            count_next = '0;
          end
          KIND_ESC: begin
            res_valid = 1'b0;
          end
          default: begin
            res_valid = 1'b1;
            if (full) begin
              res_status = ST_OVERFLOW;
              count_next = '0;
            end else begin
              res_data   = pop.item.value;
              count_next = count + 1'b1;
            end
          end
        endcase
      end
      PH_ESCAPE: begin
        res_valid = 1'b1;
        if (pop.item.kind inside {KIND_ESC_DELIM, KIND_ESC_ESC}) begin
          if (full) begin
            res_status = ST_OVERFLOW;
            count_next = '0;
          end else begin
            res_data   = (pop.item.kind == KIND_ESC_DELIM) ? DELIM_BYTE : ESC_BYTE;
            count_next = count + 1'b1;
          end
        end else begin
          res_status = ST_BADESC;
          count_next = '0;
        end
      end
      default: begin
        if (pop.item.kind == KIND_DELIM) begin
          count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        count <= count_next;
      end
      if (take && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_data   <= res_data;
      out_status <= res_status;
      out_len    <= res_len;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_data};
  assign m_tuser  = out_status;

endmodule

[src/byte_unstuffing_deframer.sv]
// Byte unstuffing deframer, top level.
// Depends on bud_pkg, bud_front, bud_queue and bud_back.
//
// Line bytes enter on the slave stream (s_tdata = line_byte). Bytes are dropped
// until the delimiter 0x41 opens a frame; inside a frame, 0x42 0x43 decodes to
// 0x41 and 0x42 0x44 decodes to 0x42, all other bytes pass through. Each decoded
// byte leaves on the master stream with status data, the closing delimiter gives
// a frame-end beat carrying the decoded length, a bad escape or a frame longer
// than max_frame_bytes gives an error beat, and the block hunts again.
// m_tuser carries the status, m_tdata carries data_byte and frame_length.
// The limit is written through cfg_we/cfg_wdata; it resets to 1024.
// Throughput is one beat per cycle in each direction while m_tready stays high.
// An accepted byte passes through the input stage register and the queue; the
// decoder works on the queue head in the cycle that loads the result register.
// When the receiver stalls, the result register holds and the queue fills;
// s_tready falls once the queue and the input stage are full. Reset empties
// the pipeline and returns the decoder to hunting.
module byte_unstuffing_deframer
  import bud_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // line_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // data_byte [7:0], frame_length [23:8]
  output logic [1:0]  m_tuser,    // status
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata   // max_frame_bytes
);

  logic [15:0] max_frame_bytes;
  item_beat_t  push;
  logic        push_ready;
  item_beat_t  pop;
  logic        pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_we) begin
      max_frame_bytes <= cfg_wdata;
    end
  end

  bud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_ready (push_ready)
  );

  bud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  bud_back u_back (
    .clk             (clk),
    .rst             (rst),
    .max_frame_bytes (max_frame_bytes),
    .pop             (pop),
    .pop_ready       (pop_ready),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser)
  );

  // Only a frame-end beat carries a length.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_END) |-> (m_tdata[23:8] == 16'd0))
    else $error("frame_length set on a beat that is not a frame end");

  // Only a data beat carries a payload byte.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DATA) |-> (m_tdata[7:0] == 8'd0))
    else $error("data_byte set on a beat that is not data");

  // Nothing is shown in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule
